>>> design/cyk_pkg.sv
// Shared types for the CYK grammar recognizer: op codes and the command word.
`default_nettype none
package cyk_pkg;

  // Op codes carried in the low bits of the input word
  typedef enum logic [1:0] {
    OP_TERM  = 2'd0,
    OP_RULE  = 2'd1,
    OP_BYTE  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Decoded command passed from the front to the engine
  typedef struct packed {
    op_t        op;
    logic [7:0] sym;
    logic [3:0] head;
    logic [3:0] left;
    logic [3:0] right;
    logic       last;
  } cmd_t;

  localparam int unsigned VarW    = 4;
  localparam int unsigned InDataW = 24;
  localparam int unsigned OutDataW = 8;

endpackage
`default_nettype wire

>>> design/cyk_front.sv
// Input side: takes stream words, decodes them and queues them for the engine.
`default_nettype none
module cyk_front
  import cyk_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [InDataW-1:0] s_tdata,
  input  wire logic               s_tlast,
  output logic                    cmd_valid,
  input  wire logic               cmd_ready,
  output cmd_t                    cmd
);

  // two-entry queue
  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       dec;
  logic       push;
  logic       pop;

  // decode one word
  always_comb begin
    dec.op    = op_t'(s_tdata[1:0]);
    dec.sym   = s_tdata[9:2];
    dec.head  = s_tdata[13:10];
    dec.left  = s_tdata[17:14];
    dec.right = s_tdata[21:18];
    dec.last  = s_tlast;
  end

  assign s_tready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = s_tvalid && s_tready;
  assign pop       = cmd_valid && cmd_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/cyk_engine.sv
// Back end: grammar tables, chart memory and the column fill sequencer.
`default_nettype none
module cyk_engine
  import cyk_pkg::*;
#(
  parameter int unsigned MAX_LEN   = 32,
  parameter int unsigned NUM_VARS  = 16,
  parameter int unsigned MAX_RULES = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  input  cmd_t                 cmd,
  input  wire logic [VarW-1:0] start_var,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_accepted,
  output logic                 out_too_long
);

  localparam int unsigned PW  = $clog2(MAX_LEN);
  localparam int unsigned LW  = $clog2(MAX_LEN + 1);
  localparam int unsigned RIW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned RCW = $clog2(MAX_RULES + 1);
  localparam int unsigned NV  = NUM_VARS;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TLOAD = 6'b000010,
    S_TCOL  = 6'b000100,
    S_FILL  = 6'b001000,
    S_FIN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  function automatic logic [NV-1:0] var_bit(input logic [VarW-1:0] v);
    logic [NV-1:0] b;
    for (int i = 0; i < int'(NV); i++) begin
      b[i] = (32'(v) == i);
    end
    return b;
  endfunction

  state_t           st;
  cmd_t             cur;
  logic [LW-1:0]    len_cnt;
  logic             ovf;
  logic [PW-1:0]    pos;
  logic [PW-1:0]    ln;
  logic [PW-1:0]    s;
  logic             issuing;
  logic             pend;
  logic [NV-1:0]    acc;
  logic [NV-1:0]    acc_next;
  logic [NV-1:0]    top;

  // binary rules, one lane per entry
  logic [VarW-1:0]  rule_h [MAX_RULES];
  logic [VarW-1:0]  rule_l [MAX_RULES];
  logic [VarW-1:0]  rule_r [MAX_RULES];
  logic [RCW-1:0]   rule_count;

  // terminal mask memory with per-entry valid bits
  logic [NV-1:0]    tmask [256];
  logic [255:0]     tvalid;
  logic [7:0]       t_addr;
  logic [NV-1:0]    rd_t;
  logic             rd_tv;
  logic [NV-1:0]    t_word;

  // chart memory, addressed {end position, length - 1}
  logic [NV-1:0]    chart [2**(2*PW)];
  logic [2*PW-1:0]  la;
  logic [2*PW-1:0]  ra;
  logic [NV-1:0]    rd_l;
  logic [NV-1:0]    rd_r;
  logic             c_we;
  logic [2*PW-1:0]  c_wa;
  logic [NV-1:0]    c_wd;

  assign pos       = len_cnt[PW-1:0];
  assign cmd_ready = (st == S_IDLE);
  assign t_addr    = (st == S_IDLE) ? cmd.sym : cur.sym;
  assign t_word    = rd_tv ? rd_t : '0;
  assign la        = {pos - ln + s - PW'(1), s - PW'(1)};
  assign ra        = {pos, ln - s};

  // all rules matched against one split
  always_comb begin
    acc_next = acc;
    for (int r = 0; r < int'(MAX_RULES); r++) begin
      if ((r < int'(rule_count)) && ((rd_l & var_bit(rule_l[r])) != '0) &&
          ((rd_r & var_bit(rule_r[r])) != '0)) begin
        acc_next = acc_next | var_bit(rule_h[r]);
      end
    end
  end

  // chart write selection
  always_comb begin
    c_we = 1'b0;
    c_wa = {pos, PW'(0)};
    c_wd = t_word;
    if (st == S_TCOL) begin
      c_we = 1'b1;
    end else if (st == S_FILL && !issuing && !pend) begin
      c_we = 1'b1;
      c_wa = {pos, ln};
      c_wd = acc;
    end
  end

  // chart memory
  always_ff @(posedge clk) begin
    if (c_we) begin
      chart[c_wa] <= c_wd;
    end
    rd_l <= chart[la];
    rd_r <= chart[ra];
  end

  // terminal mask memory
  always_ff @(posedge clk) begin
    if (st == S_TLOAD) begin
      tmask[cur.sym] <= t_word | var_bit(cur.head);
    end
    rd_t  <= tmask[t_addr];
    rd_tv <= tvalid[t_addr];
  end

  // rule storage
  always_ff @(posedge clk) begin
    if (st == S_IDLE && cmd_valid && cmd.op == OP_RULE && rule_count < RCW'(MAX_RULES)) begin
      rule_h[rule_count[RIW-1:0]] <= cmd.head;
      rule_l[rule_count[RIW-1:0]] <= cmd.left;
      rule_r[rule_count[RIW-1:0]] <= cmd.right;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      len_cnt    <= '0;
      ovf        <= 1'b0;
      rule_count <= '0;
      tvalid     <= '0;
      issuing    <= 1'b0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            unique case (cmd.op)
              OP_TERM: st <= S_TLOAD;
              OP_RULE: begin
                if (rule_count < RCW'(MAX_RULES)) begin
                  rule_count <= rule_count + RCW'(1);
                end
              end
              OP_CLEAR: begin
                tvalid     <= '0;
                rule_count <= '0;
              end
              OP_BYTE: begin
                if (len_cnt < LW'(MAX_LEN)) begin
                  st <= S_TCOL;
                end else begin
                  ovf <= 1'b1;
                  st  <= cmd.last ? S_OUT : S_IDLE;
                end
              end
              default: st <= S_IDLE;
            endcase
          end
        end
        S_TLOAD: begin
          tvalid[cur.sym] <= 1'b1;
          st              <= S_IDLE;
        end
        S_TCOL: begin
          top <= t_word;
          if (pos == '0) begin
            st <= S_FIN;
          end else begin
            ln      <= PW'(1);
            s       <= PW'(1);
            issuing <= 1'b1;
            pend    <= 1'b0;
            acc     <= '0;
            st      <= S_FILL;
          end
        end
        S_FILL: begin
          pend <= issuing;
          if (issuing) begin
            if (s == ln) begin
              issuing <= 1'b0;
            end else begin
              s <= s + PW'(1);
            end
          end
          if (pend) begin
            acc <= acc_next;
          end
          if (!issuing && !pend) begin
            top <= acc;
            if (ln == pos) begin
              st <= S_FIN;
            end else begin
              ln      <= ln + PW'(1);
              s       <= PW'(1);
              issuing <= 1'b1;
              acc     <= '0;
            end
          end
        end
        S_FIN: begin
          len_cnt <= len_cnt + LW'(1);
          st      <= cur.last ? S_OUT : S_IDLE;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            out_accepted <= !ovf && (len_cnt != '0) && ((top & var_bit(start_var)) != '0);
            out_too_long <= ovf;
            len_cnt      <= '0;
            ovf          <= 1'b0;
            st           <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/cyk_grammar_recognizer_top.sv
// Top level of the CYK grammar recognizer: start variable register and wiring.
//
//   channel  dir  tdata fields (low bit up)                        side bits
//   s_axis   in   op[1:0] symbol_byte[9:2] head_var[13:10]          tlast = last
//                 left_var[17:14] right_var[21:18], zero fill
//   m_axis   out  accepted[0] too_long[1], zero fill                none
//   cfg      in   start_var on cfg_wr_data when cfg_wr_en           none
//
// Rule loads and grammar clears are handled in the idle state; terminal loads pass
// through a table load state. A string byte at position p fills its chart column
// for lengths l = 2..p+1, one chart split read per cycle with all rules matched at
// once, and each length's result is written after its splits. Reset is synchronous and
// clears the grammar; a two-word queue lets input words land while the engine works.
`default_nettype none
module cyk_grammar_recognizer_top
  import cyk_pkg::*;
#(
  parameter int unsigned MAX_LEN   = 32,
  parameter int unsigned NUM_VARS  = 16,
  parameter int unsigned MAX_RULES = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // op, symbol_byte, head_var, left_var, right_var from bit 0
  input  wire logic [InDataW-1:0]  s_tdata,
  input  wire logic                s_tlast,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // accepted, too_long from bit 0
  output logic [OutDataW-1:0]      m_tdata,
  input  wire logic                cfg_wr_en,
  input  wire logic [VarW-1:0]     cfg_wr_data
);

  logic [VarW-1:0] start_var;
  logic            cmd_valid;
  logic            cmd_ready;
  cmd_t            cmd;
  logic            acc_bit;
  logic            long_bit;

  // start variable register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_var <= '0;
    end else if (cfg_wr_en) begin
      start_var <= cfg_wr_data;
    end
  end

  cyk_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  cyk_engine #(
    .MAX_LEN   (MAX_LEN),
    .NUM_VARS  (NUM_VARS),
    .MAX_RULES (MAX_RULES)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .start_var    (start_var),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_accepted (acc_bit),
    .out_too_long (long_bit)
  );

  assign m_tdata = {{(OutDataW - 2){1'b0}}, long_bit, acc_bit};

endmodule
`default_nettype wire
